FILE: design/text_console_cell_engine_assert.svh
// Assertion macros shared by the console engine RTL.
`ifndef TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TXCON_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("txcon: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TXCON_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("txcon: next-cycle check failed");

`endif

FILE: design/txcon_pkg.sv
// Types and constants for the text console cell engine.
`default_nettype none

package txcon_pkg;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [2:0] KIND_PUT   = 3'd0;
  localparam logic [2:0] KIND_SET   = 3'd1;
  localparam logic [2:0] KIND_DEL   = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 4'd1;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;
  localparam logic [15:0] BLANK_RESET = {BG_RESET, FG_RESET, CH_SPACE};

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_RDWAIT = 5'b00100,
    ST_SWEEP  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

FILE: design/text_console_cell_engine.sv
// Text console cell engine: screen store, cursor and command sequencer.
//
// Input beats on s_* carry one command: put character, set cursor, delete
// last, clear screen or read cell. Every command yields exactly one result
// beat on m_* with the cursor after the command, the cell read and a scroll
// flag. cfg_* writes the foreground and background color of the attribute;
// it is always ready; the user is to write it only while the engine is idle,
// which the engine itself does not enforce. The screen lives in one
// single-port memory of ROWS*COLS cells, rows kept as a ring with a top-row
// pointer so a scroll only blanks one row. A cursor-only command passes IDLE
// and DONE; a cell write or read also passes EXEC, and a read then RDWAIT;
// in SWEEP a scroll then blanks one row and a clear the whole memory.
// s_tready is high whenever no command is in flight; a finished result waits
// in the output register, so one more command may be taken meanwhile, and
// its result is held back until m_tready frees that register.
// Reset runs a blanking pass over the whole memory with s_tready low;
// configuration writes are taken during it.
`default_nettype none
`include "text_console_cell_engine_assert.svh"

module text_console_cell_engine #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // kind[2:0], character[10:3], target_row[18:11], target_column[26:19]
  input  wire logic [txcon_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // cursor_row_now[4:0], cursor_column_now[11:5], cursor_position[22:12],
  // cell_value[38:23], did_scroll[39]
  output logic [txcon_pkg::M_TDATA_W-1:0]          m_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [txcon_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [txcon_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  txcon_pkg::state_t state;

  logic [3:0]      fg_color;
  logic [3:0]      bg_color;
  logic [7:0]      attr;

  logic [RW-1:0]   cur_row;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   top;

  logic [RW-1:0]   op_row;
  logic [CW-1:0]   op_col;
  logic [7:0]      op_char;
  logic            op_wr;
  logic            op_rd;
  logic            op_scroll;
  logic            op_clear;

  logic [15:0]     res_cell;
  logic            res_scroll;

  logic [AW-1:0]   sweep_addr;
  logic [AW-1:0]   sweep_last;
  logic [15:0]     sweep_fill;
  logic            sweep_report;

  logic [15:0]     mem [CELLS];
  logic [15:0]     rd_data;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;
  logic [15:0]     mem_wdata;

  logic [2:0]      in_kind;
  logic [7:0]      in_char;
  logic [7:0]      in_row;
  logic [7:0]      in_col;

  logic [RW:0]     row_w;
  logic [CW:0]     col_w;
  logic [RW-1:0]   wr_row;
  logic [CW-1:0]   wr_col;
  logic [7:0]      wr_char;
  logic            wr_en;
  logic            rd_en;
  logic            scroll_en;
  logic            clear_en;

  logic [RW:0]     phys_sum;
  logic [RW-1:0]   phys_row;
  logic [AW-1:0]   op_addr;
  logic [AW-1:0]   top_base;
  logic [AW-1:0]   cur_pos;
  logic            accept;
  logic            out_free;

  assign in_kind  = s_tdata[2:0];
  assign in_char  = s_tdata[10:3];
  assign in_row   = s_tdata[18:11];
  assign in_col   = s_tdata[26:19];

  assign attr      = {bg_color, fg_color};
  assign s_tready  = (state == txcon_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Command decode and next cursor.
  always_comb begin
    row_w     = {1'b0, cur_row};
    col_w     = {1'b0, cur_col};
    wr_row    = cur_row;
    wr_col    = cur_col;
    wr_char   = in_char;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    scroll_en = 1'b0;
    clear_en  = 1'b0;
    unique case (in_kind)
      txcon_pkg::KIND_PUT: begin
        unique case (in_char)
          txcon_pkg::CH_NEWLINE: begin
            col_w = '0;
            row_w = row_w + (RW+1)'(1);
          end
          txcon_pkg::CH_RETURN: begin
            col_w = '0;
          end
          txcon_pkg::CH_TAB: begin
            col_w = (col_w + (CW+1)'(8)) & ~(CW+1)'(7);
          end
          txcon_pkg::CH_BACKSPACE: begin
            if (cur_col != '0) begin
              col_w   = col_w - (CW+1)'(1);
              wr_col  = cur_col - CW'(1);
              wr_char = txcon_pkg::CH_SPACE;
              wr_en   = 1'b1;
            end
          end
          default: begin
            wr_en = 1'b1;
            col_w = col_w + (CW+1)'(1);
          end
        endcase
        if (col_w >= (CW+1)'(COLS)) begin
          col_w = '0;
          row_w = row_w + (RW+1)'(1);
        end
        if (row_w >= (RW+1)'(ROWS)) begin
          scroll_en = 1'b1;
          row_w     = (RW+1)'(ROWS - 1);
        end
      end
      txcon_pkg::KIND_SET: begin
        if (in_row < 8'(ROWS)) begin
          row_w = (RW+1)'(in_row);
        end
        if (in_col < 8'(COLS)) begin
          col_w = (CW+1)'(in_col);
        end
      end
      txcon_pkg::KIND_DEL: begin
        if (cur_col != '0) begin
          col_w = col_w - (CW+1)'(1);
        end else if (cur_row != '0) begin
          row_w = row_w - (RW+1)'(1);
          col_w = (CW+1)'(COLS - 1);
        end
        wr_row  = row_w[RW-1:0];
        wr_col  = col_w[CW-1:0];
        wr_char = txcon_pkg::CH_SPACE;
        wr_en   = 1'b1;
      end
      txcon_pkg::KIND_CLEAR: begin
        row_w    = '0;
        col_w    = '0;
        clear_en = 1'b1;
      end
      txcon_pkg::KIND_READ: begin
        if (in_row < 8'(ROWS) && in_col < 8'(COLS)) begin
          rd_en  = 1'b1;
          wr_row = in_row[RW-1:0];
          wr_col = in_col[CW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Logical row to ring row, then cell address.
  always_comb begin
    phys_sum = {1'b0, top} + {1'b0, op_row};
    if (phys_sum >= (RW+1)'(ROWS)) begin
      phys_row = RW'(phys_sum - (RW+1)'(ROWS));
    end else begin
      phys_row = phys_sum[RW-1:0];
    end
    op_addr  = AW'(phys_row) * AW'(COLS) + AW'(op_col);
    top_base = AW'(top) * AW'(COLS);
    cur_pos  = AW'(cur_row) * AW'(COLS) + AW'(cur_col);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = op_addr;
    mem_wdata = {attr, op_char};
    unique case (state)
      txcon_pkg::ST_EXEC: begin
        mem_we = op_wr;
        mem_re = op_rd;
      end
      txcon_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_addr;
        mem_wdata = sweep_fill;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= txcon_pkg::FG_RESET;
      bg_color <= txcon_pkg::BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == txcon_pkg::REG_FOREGROUND) begin
        fg_color <= cfg_data;
      end else if (cfg_index == txcon_pkg::REG_BACKGROUND) begin
        bg_color <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= txcon_pkg::ST_SWEEP;
      cur_row      <= '0;
      cur_col      <= '0;
      top          <= '0;
      sweep_addr   <= '0;
      sweep_last   <= AW'(CELLS - 1);
      sweep_fill   <= txcon_pkg::BLANK_RESET;
      sweep_report <= 1'b0;
      op_wr        <= 1'b0;
      op_rd        <= 1'b0;
      op_scroll    <= 1'b0;
      op_clear     <= 1'b0;
    end else begin
      unique case (state)
        txcon_pkg::ST_IDLE: begin
          if (accept) begin
            cur_row    <= row_w[RW-1:0];
            cur_col    <= col_w[CW-1:0];
            op_row     <= wr_row;
            op_col     <= wr_col;
            op_char    <= wr_char;
            op_wr      <= wr_en;
            op_rd      <= rd_en;
            op_scroll  <= scroll_en;
            op_clear   <= clear_en;
            res_cell   <= '0;
            res_scroll <= scroll_en;
            if (wr_en || rd_en || scroll_en || clear_en) begin
              state <= txcon_pkg::ST_EXEC;
            end else begin
              state <= txcon_pkg::ST_DONE;
            end
          end
        end
        txcon_pkg::ST_EXEC: begin
          sweep_fill   <= {attr, txcon_pkg::CH_SPACE};
          sweep_report <= 1'b1;
          priority if (op_rd) begin
            state <= txcon_pkg::ST_RDWAIT;
          end else if (op_scroll) begin
            // Old top row becomes the new bottom row.
            sweep_addr <= top_base;
            sweep_last <= top_base + AW'(COLS - 1);
            top        <= (top == RW'(ROWS - 1)) ? '0 : top + RW'(1);
            state      <= txcon_pkg::ST_SWEEP;
          end else if (op_clear) begin
            sweep_addr <= '0;
            sweep_last <= AW'(CELLS - 1);
            top        <= '0;
            state      <= txcon_pkg::ST_SWEEP;
          end else begin
            state <= txcon_pkg::ST_DONE;
          end
        end
        txcon_pkg::ST_RDWAIT: begin
          res_cell <= rd_data;
          state    <= txcon_pkg::ST_DONE;
        end
        txcon_pkg::ST_SWEEP: begin
          if (sweep_addr == sweep_last) begin
            state <= sweep_report ? txcon_pkg::ST_DONE : txcon_pkg::ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + AW'(1);
          end
        end
        txcon_pkg::ST_DONE: begin
          if (out_free) begin
            state <= txcon_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= txcon_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == txcon_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == txcon_pkg::ST_DONE && out_free) begin
      m_tdata <= {res_scroll, res_cell, 11'(cur_pos), 7'(cur_col), 5'(cur_row)};
    end
  end

  `TXCON_ASSERT_NXT(a_accept_leaves_idle, clk, rst, accept, state != txcon_pkg::ST_IDLE)
  `TXCON_ASSERT_IMP(a_cursor_in_range, clk, rst, 1'b1, (cur_row < RW'(ROWS - 1) || cur_row == RW'(ROWS - 1)) && (cur_col < CW'(COLS - 1) || cur_col == CW'(COLS - 1)))
  `TXCON_ASSERT_IMP(a_top_in_range, clk, rst, 1'b1, top < RW'(ROWS - 1) || top == RW'(ROWS - 1))
  `TXCON_ASSERT_IMP(a_no_write_idle, clk, rst, mem_we, state != txcon_pkg::ST_IDLE)
  `TXCON_ASSERT_IMP(a_result_from_done, clk, rst, $rose(m_tvalid), $past(state == txcon_pkg::ST_DONE))

endmodule

`default_nettype wire
